// File: rtl/nsc_pkg.sv
// ============================================================================
// nsc_pkg: shared types and constants of the NMEA sentence checker
// Character codes, status codes, counter widths and the result item type.
// ============================================================================
package nsc_pkg;

  // Largest comma count that the field counter holds.
  localparam int MAX_FIELD_INDEX = 31;

  // The counter is at least as wide as the reported field number.
  localparam int FC_W = ($clog2(MAX_FIELD_INDEX + 1) < 5) ? 5 : $clog2(MAX_FIELD_INDEX + 1);

  // Largest field number that the result carries.
  localparam int FNUM_SAT = 31;

  // Character codes.
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Sentence types, as the last three bytes of the address field.
  localparam logic [23:0] TYPE_GGA = 24'h474741;
  localparam logic [23:0] TYPE_GLL = 24'h474C4C;

  // Address length of a valid talker plus type, and field minimums.
  localparam logic [2:0] ADDR_LEN_OK    = 3'd5;
  localparam logic [2:0] ADDR_LEN_MAX   = 3'd7;
  localparam int         GGA_MIN_FIELDS = 13;
  localparam int         GLL_MIN_FIELDS = 7;

  // Status codes.
  localparam logic [2:0] ST_PENDING   = 3'd0;
  localparam logic [2:0] ST_GGA_OK    = 3'd1;
  localparam logic [2:0] ST_GLL_OK    = 3'd2;
  localparam logic [2:0] ST_NO_START  = 3'd3;
  localparam logic [2:0] ST_BAD_FMT   = 3'd4;
  localparam logic [2:0] ST_MISMATCH  = 3'd5;
  localparam logic [2:0] ST_UNKNOWN   = 3'd6;
  localparam logic [2:0] ST_FEW_FIELD = 3'd7;

  // One result item.
  typedef struct packed {
    logic [7:0] char_out;
    logic [4:0] field_number;
    logic       is_field_content;
    logic       sentence_done;
    logic [2:0] status;
  } nsc_result_t;

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b1, 4'(c - 8'h37)};
    end
    return d;
  endfunction

endpackage

// File: rtl/nmea_sentence_checker_core.sv
// ============================================================================
// nmea_sentence_checker_core: NMEA 0183 sentence checksum and type checker
// The result item of an accepted byte is registered and shows the next cycle.
// Throughput: one byte per cycle unless stalled; the parse state is updated
// by one pass of logic between the input handshake and the result register.
// Reset: synchronous, active low; clears the parse state and the result valid.
// Each byte is echoed with its field number; the last byte carries a status.
// ============================================================================
module nmea_sentence_checker_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic [4:0] out_field_number,
  output logic       out_is_field_content,
  output logic       out_sentence_done,
  output logic [2:0] out_status
);
  import nsc_pkg::*;

  logic        in_fire;
  logic        out_valid_r;
  nsc_result_t res;
  nsc_result_t res_r;

  // A new item is taken unless the result register is full and held.
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  nsc_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (in_fire),
    .char_in  (in_char_in),
    .line_end (in_line_end),
    .result   (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_char_out         = res_r.char_out;
  assign out_field_number     = res_r.field_number;
  assign out_is_field_content = res_r.is_field_content;
  assign out_sentence_done    = res_r.sentence_done;
  assign out_status           = res_r.status;

  // A finished line always carries a final status.
  a_done_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.sentence_done |-> res_r.status != ST_PENDING)
    else $error("line end without a final status");

  // Bytes before the line end report pending status.
  a_pending_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !res_r.sentence_done |-> res_r.status == ST_PENDING)
    else $error("status reported before line end");

  // An accepted item always shows up in the result register.
  a_fire_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r && res_r.char_out == $past(in_char_in))
    else $error("accepted item not loaded into result register");

endmodule

// File: rtl/nsc_parser.sv
// ============================================================================
// nsc_parser: per-byte sentence parse state and result decode
// Holds the parse phase, checksum, field count and address bytes, and works
// out the result item for each accepted byte in one pass.
// ============================================================================
module nsc_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [7:0]           char_in,
  input  logic                 line_end,
  output nsc_pkg::nsc_result_t result
);
  import nsc_pkg::*;

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_DATA  = 2'd1;
  localparam logic [1:0] PH_HEX   = 2'd2;
  localparam logic [1:0] PH_TAIL  = 2'd3;

  logic [1:0]      phase_r, phase_nxt;
  logic [7:0]      xor_r, xor_nxt;
  logic [7:0]      given_r, given_nxt;
  logic            hex_seen_r, hex_seen_nxt;
  logic [FC_W-1:0] fcount_r, fcount_nxt;
  logic [2:0]      alen_r, alen_nxt;
  logic [23:0]     type_r, type_nxt;
  logic            no_start_r, no_start_nxt;
  logic            star_again_r, star_again_nxt;
  logic            last_comma_r, last_comma_nxt;
  logic            data_seen_r, data_seen_nxt;

  logic [4:0]      hex;
  logic [FC_W:0]   fields;
  logic            fnum_live;
  logic            content;
  logic [2:0]      status;

  assign hex = hex_digit(char_in);

  // Next parse state for this byte.
  always_comb begin
    phase_nxt      = phase_r;
    xor_nxt        = xor_r;
    given_nxt      = given_r;
    hex_seen_nxt   = hex_seen_r;
    fcount_nxt     = fcount_r;
    alen_nxt       = alen_r;
    type_nxt       = type_r;
    no_start_nxt   = no_start_r;
    star_again_nxt = star_again_r;
    last_comma_nxt = last_comma_r;
    data_seen_nxt  = data_seen_r;
    fnum_live      = 1'b0;
    content        = 1'b0;
    if (no_start_r) begin
      // The line already failed; the rest is ignored.
    end else if (phase_r == PH_START) begin
      if (char_in == CH_DOLLAR) begin
        phase_nxt = PH_DATA;
      end else begin
        no_start_nxt = 1'b1;
      end
    end else if (phase_r == PH_DATA) begin
      fnum_live = 1'b1;
      if (char_in == CH_STAR) begin
        phase_nxt = PH_HEX;
      end else begin
        xor_nxt       = xor_r ^ char_in;
        data_seen_nxt = 1'b1;
        if (char_in == CH_COMMA) begin
          last_comma_nxt = 1'b1;
          if (fcount_r < FC_W'(MAX_FIELD_INDEX)) begin
            fcount_nxt = fcount_r + 1'b1;
          end
        end else begin
          last_comma_nxt = 1'b0;
          content        = 1'b1;
          if (fcount_r == '0) begin
            if (alen_r < ADDR_LEN_MAX) begin
              alen_nxt = alen_r + 1'b1;
            end
            type_nxt = {type_r[15:0], char_in};
          end
        end
      end
    end else begin
      fnum_live = 1'b1;
      if (char_in == CH_STAR) begin
        star_again_nxt = 1'b1;
      end else if (phase_r == PH_HEX) begin
        if (hex[4]) begin
          given_nxt    = {given_r[3:0], hex[3:0]};
          hex_seen_nxt = 1'b1;
        end else begin
          phase_nxt = PH_TAIL;
        end
      end
    end
  end

  // Fields are the commas plus one, unless the data part is empty or ends in a comma.
  assign fields = {1'b0, fcount_nxt} + (FC_W+1)'(data_seen_nxt && !last_comma_nxt);

  // Line status, checked in order: start, format, checksum, then type and field count.
  always_comb begin
    status = ST_PENDING;
    if (line_end) begin
      if (no_start_nxt) begin
        status = ST_NO_START;
      end else if (phase_nxt == PH_START || phase_nxt == PH_DATA || star_again_nxt ||
                   !hex_seen_nxt) begin
        status = ST_BAD_FMT;
      end else if (xor_nxt != given_nxt) begin
        status = ST_MISMATCH;
      end else if (alen_nxt == ADDR_LEN_OK && type_nxt == TYPE_GGA) begin
        status = (fields >= (FC_W+1)'(GGA_MIN_FIELDS)) ? ST_GGA_OK : ST_FEW_FIELD;
      end else if (alen_nxt == ADDR_LEN_OK && type_nxt == TYPE_GLL) begin
        status = (fields >= (FC_W+1)'(GLL_MIN_FIELDS)) ? ST_GLL_OK : ST_FEW_FIELD;
      end else begin
        status = ST_UNKNOWN;
      end
    end
  end

  // Result item for this byte.
  always_comb begin
    result.char_out         = char_in;
    result.field_number     = '0;
    if (fnum_live) begin
      result.field_number = (fcount_r > FC_W'(FNUM_SAT)) ? 5'(FNUM_SAT) : fcount_r[4:0];
    end
    result.is_field_content = content;
    result.sentence_done    = line_end;
    result.status           = status;
  end

  // State registers; the last byte of a line returns everything to reset values.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && line_end)) begin
      phase_r      <= PH_START;
      xor_r        <= '0;
      given_r      <= '0;
      hex_seen_r   <= 1'b0;
      fcount_r     <= '0;
      alen_r       <= '0;
      type_r       <= '0;
      no_start_r   <= 1'b0;
      star_again_r <= 1'b0;
      last_comma_r <= 1'b0;
      data_seen_r  <= 1'b0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      xor_r        <= xor_nxt;
      given_r      <= given_nxt;
      hex_seen_r   <= hex_seen_nxt;
      fcount_r     <= fcount_nxt;
      alen_r       <= alen_nxt;
      type_r       <= type_nxt;
      no_start_r   <= no_start_nxt;
      star_again_r <= star_again_nxt;
      last_comma_r <= last_comma_nxt;
      data_seen_r  <= data_seen_nxt;
    end
  end

  // A finished line leaves the parser waiting for a new start character.
  a_line_restart: assert property (@(posedge clk) disable iff (!rst_n)
    fire && line_end |=> phase_r == PH_START && fcount_r == '0 && !no_start_r)
    else $error("parser state not cleared after line end");

  // A failed start never leaves the start phase.
  a_no_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
    no_start_r |-> phase_r == PH_START)
    else $error("parser left start phase on a line without start");

  // Field content only comes from the data phase.
  a_content_phase: assert property (@(posedge clk) disable iff (!rst_n)
    content |-> phase_r == PH_DATA && !no_start_r)
    else $error("field content flagged outside data phase");

endmodule

// File: verif/nsc_tb_pkg.sv
// ============================================================================
// nsc_tb_pkg: sentence tracker for the NMEA sentence checker testbench
// Follows each accepted byte through its own parse of the sentence, queues the
// result item that the checker must return for it, and compares the returned
// result items with that queue in order.
// ============================================================================
`timescale 1ns / 100ps

package nsc_tb_pkg;
  import nsc_pkg::*;

  class sentence_scoreboard;
    typedef enum logic [1:0] {
      WAIT_DOLLAR,
      IN_BODY,
      IN_DIGITS,
      AFTER_DIGITS
    } parse_phase_t;

    // Parse state of the line in progress.
    parse_phase_t phase;
    logic [7:0]   body_xor;
    logic [7:0]   sum_given;
    bit           digit_seen;
    int           commas;
    int           addr_len;
    logic [23:0]  addr_tail;
    bit           no_dollar;
    bit           extra_star;
    bit           ends_comma;
    bit           body_seen;

    // Result items still owed by the checker, oldest first.
    nsc_result_t  expected_echoes[$];

    int           mismatches;
    int           parsed_bytes;
    int           lines_done;
    int           status_count[8];

    function new();
      clear_line();
    endfunction

    function void clear_line();
      phase      = WAIT_DOLLAR;
      body_xor   = '0;
      sum_given  = '0;
      digit_seen = 1'b0;
      commas     = 0;
      addr_len   = 0;
      addr_tail  = '0;
      no_dollar  = 1'b0;
      extra_star = 1'b0;
      ends_comma = 1'b0;
      body_seen  = 1'b0;
    endfunction

    // Value of a hex digit in either case, or -1 for any other byte.
    function int nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function logic [4:0] field_index();
      return (commas > FNUM_SAT) ? 5'(FNUM_SAT) : 5'(commas);
    endfunction

    // Verdict for the line: start, format, checksum, then type and field count.
    function logic [2:0] line_status();
      int fields;
      if (no_dollar) return ST_NO_START;
      if (phase == WAIT_DOLLAR || phase == IN_BODY || extra_star || !digit_seen) begin
        return ST_BAD_FMT;
      end
      if (body_xor != sum_given) return ST_MISMATCH;
      fields = commas + ((body_seen && !ends_comma) ? 1 : 0);
      if (addr_len == ADDR_LEN_OK && addr_tail == TYPE_GGA) begin
        return (fields >= GGA_MIN_FIELDS) ? ST_GGA_OK : ST_FEW_FIELD;
      end
      if (addr_len == ADDR_LEN_OK && addr_tail == TYPE_GLL) begin
        return (fields >= GLL_MIN_FIELDS) ? ST_GLL_OK : ST_FEW_FIELD;
      end
      return ST_UNKNOWN;
    endfunction

    // Advance the parse by one accepted byte and queue the result it causes.
    function void parse_byte(logic [7:0] c, logic last);
      nsc_result_t exp;
      int          d;
      exp = '0;
      exp.char_out = c;
      exp.sentence_done = last;
      exp.status = ST_PENDING;
      if (no_dollar) begin
        // The line has already failed; its remaining bytes are ignored.
      end else if (phase == WAIT_DOLLAR) begin
        if (c == CH_DOLLAR) phase = IN_BODY;
        else no_dollar = 1'b1;
      end else if (phase == IN_BODY) begin
        exp.field_number = field_index();
        if (c == CH_STAR) begin
          phase = IN_DIGITS;
        end else begin
          body_xor ^= c;
          body_seen = 1'b1;
          if (c == CH_COMMA) begin
            ends_comma = 1'b1;
            if (commas < MAX_FIELD_INDEX) commas++;
          end else begin
            ends_comma = 1'b0;
            exp.is_field_content = 1'b1;
            if (commas == 0) begin
              if (addr_len < ADDR_LEN_MAX) addr_len++;
              addr_tail = {addr_tail[15:0], c};
            end
          end
        end
      end else begin
        exp.field_number = field_index();
        if (c == CH_STAR) begin
          extra_star = 1'b1;
        end else if (phase == IN_DIGITS) begin
          d = nibble(c);
          if (d >= 0) begin
            sum_given = {sum_given[3:0], d[3:0]};
            digit_seen = 1'b1;
          end else begin
            phase = AFTER_DIGITS;
          end
        end
      end
      if (!no_dollar) parsed_bytes++;
      if (last) begin
        exp.status = line_status();
        status_count[exp.status]++;
        lines_done++;
        clear_line();
      end
      expected_echoes = {expected_echoes, exp};
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one returned result item with the oldest one owed.
    function void check_echo(nsc_result_t got);
      nsc_result_t want;
      if (expected_echoes.size() == 0) begin
        $error("result item with no byte outstanding: char_out %0h", got.char_out);
        mismatches++;
        return;
      end
      want = expected_echoes.pop_front();
      compare_field("char_out", want.char_out, got.char_out);
      compare_field("field_number", want.field_number, got.field_number);
      compare_field("is_field_content", want.is_field_content, got.is_field_content);
      compare_field("sentence_done", want.sentence_done, got.sentence_done);
      compare_field("status", want.status, got.status);
    endfunction

    function bit drained();
      return expected_echoes.size() == 0;
    endfunction
  endclass

endpackage

// File: verif/testbench.sv
// ============================================================================
// testbench: randomized sentence test of nmea_sentence_checker_core
// Feeds short directed lines and then random NMEA sentences, mostly well
// formed GGA and GLL lines with random content and at most one flaw each, plus
// noise. Both channel sides idle at random; every result item is checked.
// ============================================================================
`timescale 1ns / 100ps

module testbench;
  import nsc_pkg::*;
  import nsc_tb_pkg::*;

  localparam int ITEM_GOAL   = 2000;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD   = 400;

  typedef enum int {
    FLAW_NONE,
    FLAW_SUM,
    FLAW_NO_DOLLAR,
    FLAW_NO_STAR,
    FLAW_TWO_STARS,
    FLAW_NO_DIGITS,
    FLAW_ADDR_LEN,
    FLAW_TYPE,
    FLAW_FEW_FIELDS,
    FLAW_MANY_FIELDS,
    FLAW_EMPTY_TAIL,
    FLAW_NOISE
  } line_flaw_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_char_in;
  logic       in_line_end;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_char_out;
  logic [4:0] out_field_number;
  logic       out_is_field_content;
  logic       out_sentence_done;
  logic [2:0] out_status;

  sentence_scoreboard tracker = new();
  logic [7:0]         line_q[$];
  bit                 quiet_line;
  int                 cycles = 0;

  nmea_sentence_checker_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_char_in           (in_char_in),
    .in_line_end          (in_line_end),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_char_out         (out_char_out),
    .out_field_number     (out_field_number),
    .out_is_field_content (out_is_field_content),
    .out_sentence_done    (out_sentence_done),
    .out_status           (out_status)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Idle length: mostly none, sometimes short, rarely long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] letter();
    return 8'h41 + 8'($urandom_range(0, 25));
  endfunction

  // Field content: printable as a rule, any byte now and then, never a separator.
  function automatic logic [7:0] content_byte();
    logic [7:0] c;
    do begin
      if ($urandom_range(0, 9) == 0) c = 8'($urandom_range(0, 255));
      else c = 8'($urandom_range(8'h20, 8'h7E));
    end while (c == CH_STAR || c == CH_COMMA);
    return c;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
    if (v < 4'd10) return 8'h30 + v;
    return (lower ? 8'h57 : 8'h37) + v;
  endfunction

  function automatic void load_text(string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q = {line_q, s[i]};
  endfunction

  // Build one random line into line_q: a GGA or GLL sentence with at most one
  // flaw, or a burst of noise.
  function automatic void build_sentence();
    logic [7:0]  body[$];
    logic [7:0]  sum;
    logic [7:0]  c;
    logic [23:0] type_code;
    line_flaw_t  flaw;
    int          len;
    int          ncommas;
    bit          gga;
    bit          lower;
    bit          star_late;
    line_q.delete();
    flaw = ($urandom_range(0, 1) == 0) ? FLAW_NONE : line_flaw_t'($urandom_range(1, 11));
    gga = $urandom_range(0, 1);
    lower = $urandom_range(0, 1);
    type_code = gga ? TYPE_GGA : TYPE_GLL;

    if (flaw == FLAW_NOISE) begin
      len = $urandom_range(1, 12);
      repeat (len) line_q = {line_q, 8'($urandom_range(0, 255))};
      if ($urandom_range(0, 1) == 1) line_q[0] = CH_DOLLAR;
      return;
    end

    // Address field: talker plus type, or a wrong length or type.
    len = 5;
    if (flaw == FLAW_ADDR_LEN) begin
      case ($urandom_range(0, 3))
        0: len = 3;
        1: len = 4;
        2: len = 6;
        default: len = 9;
      endcase
    end
    repeat (len - 3) body = {body, letter()};
    if (flaw == FLAW_TYPE) begin
      repeat (3) body = {body, letter()};
    end else begin
      body = {body, type_code[23:16], type_code[15:8], type_code[7:0]};
    end

    // Data fields; the last one is kept non-empty so clean lines pass.
    if (flaw == FLAW_FEW_FIELDS) ncommas = $urandom_range(0, gga ? 11 : 5);
    else if (flaw == FLAW_MANY_FIELDS) ncommas = $urandom_range(30, 40);
    else ncommas = gga ? $urandom_range(12, 14) : $urandom_range(6, 8);
    for (int i = 0; i < ncommas; i++) begin
      body = {body, CH_COMMA};
      len = (i == ncommas - 1) ? $urandom_range(1, 3) : $urandom_range(0, 3);
      repeat (len) body = {body, content_byte()};
    end
    if (flaw == FLAW_EMPTY_TAIL) begin
      if ($urandom_range(0, 1) == 1) body = {body, CH_COMMA};
      else body.delete();
    end

    sum = '0;
    foreach (body[i]) sum ^= body[i];
    if (flaw == FLAW_SUM) sum ^= 8'($urandom_range(1, 255));

    if (flaw != FLAW_NO_DOLLAR) begin
      line_q = {line_q, CH_DOLLAR};
    end else if ($urandom_range(0, 1) == 1) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_DOLLAR);
      line_q = {line_q, c};
    end
    line_q = {line_q, body};

    // Checksum digits, sometimes with extra leading digits that shift out.
    star_late = $urandom_range(0, 1);
    if (flaw != FLAW_NO_STAR) begin
      line_q = {line_q, CH_STAR};
      if (flaw != FLAW_NO_DIGITS) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            line_q = {line_q, hex_char(4'($urandom_range(0, 15)), lower)};
          end
        end
        line_q = {line_q, hex_char(sum[7:4], lower), hex_char(sum[3:0], lower)};
      end
      if (flaw == FLAW_TWO_STARS && !star_late) line_q = {line_q, CH_STAR};
    end
    if ($urandom_range(0, 4) != 0) begin
      line_q = {line_q, 8'h0D, 8'h0A};
    end
    if (flaw == FLAW_TWO_STARS && star_late) line_q = {line_q, CH_STAR};
  endfunction

  // Offer one byte after a random gap and hold it until it is taken.
  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = quiet_line ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_char_in  <= c;
    in_line_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.parse_byte(c, last);
  endtask

  task automatic send_line();
    quiet_line = ($urandom_range(0, 5) == 0);
    foreach (line_q[i]) send_byte(line_q[i], i == line_q.size() - 1);
  endtask

  // Stop offering until every owed result item has come back.
  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (!tracker.drained());
  endtask

  // Stimulus: reset, directed lines, then random sentences.
  initial begin : stimulus
    int lines;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_char_in  <= '0;
    in_line_end <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Missing start, byte extremes, truncated lines, star and digit corner cases.
    load_text("x");
    send_line();
    line_q = '{8'h00, 8'hFF};
    send_line();
    load_text("$");
    send_line();
    load_text("$*");
    send_line();
    load_text("$*0");
    send_line();
    load_text("$*00*");
    send_line();
    load_text("$,*2c");
    send_line();
    load_text("$A*41Z");
    send_line();

    lines = 0;
    while (tracker.parsed_bytes < ITEM_GOAL) begin
      if (lines % 9 == 8) drain_pause();
      build_sentence();
      send_line();
      lines++;
    end

    drain_pause();
    repeat (8) @(posedge clk);
    $display("Checked %0d lines and %0d parsed bytes; statuses seen: GGA ok %0d, GLL ok %0d,",
             tracker.lines_done, tracker.parsed_bytes,
             tracker.status_count[ST_GGA_OK], tracker.status_count[ST_GLL_OK]);
    $display("no start %0d, bad format %0d, mismatch %0d, unknown %0d, too few fields %0d",
             tracker.status_count[ST_NO_START], tracker.status_count[ST_BAD_FMT],
             tracker.status_count[ST_MISMATCH], tracker.status_count[ST_UNKNOWN],
             tracker.status_count[ST_FEW_FIELD]);
    if (tracker.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off while bytes keep coming.
  initial begin : receiver
    int  hold;
    bit  long_done;
    hold = 0;
    long_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (!long_done && tracker.parsed_bytes >= 600) begin
        long_done = 1'b1;
        hold = LONG_HOLD - 1;
        out_stall <= 1'b1;
      end else if (quiet_line) begin
        out_stall <= 1'b0;
      end else begin
        hold = idle_len();
        if (hold > 0) begin
          out_stall <= 1'b1;
          hold--;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_echo(nsc_result_t'{char_out:         out_char_out,
                                       field_number:     out_field_number,
                                       is_field_content: out_is_field_content,
                                       sentence_done:    out_sentence_done,
                                       status:           out_status});
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles", CYCLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
